// File: rtl/crp_pkg.sv
// ----------------------------------------------------------------------------
// crp_pkg - card reader record parser shared definitions
// Constants, event codes and the result word layout.
// ----------------------------------------------------------------------------
`default_nettype none

package crp_pkg;

    // Token store and length limit
    localparam int TOKEN_STORE_BYTES = 16;
    localparam int MAX_TOKEN         = 32;
    localparam int REPORT_BYTES      = 16;
    localparam int CNT_W             = $clog2(MAX_TOKEN + 1);
    localparam int STORE_IDX_W       = $clog2(TOKEN_STORE_BYTES);
    localparam int CFG_W             = 6;

    // Stream widths
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 144;
    localparam int OUT_USER_W = 3;

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_L     = 8'h4C;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_TWO   = 8'h32;

    // Alarm codes
    localparam logic [1:0] ALARM_NONE = 2'd0;
    localparam logic [1:0] ALARM_ONE  = 2'd1;
    localparam logic [1:0] ALARM_TWO  = 2'd2;

    typedef enum logic [2:0] {
        EV_DATE    = 3'd0,
        EV_TIME    = 3'd1,
        EV_BANK    = 3'd2,
        EV_ACCOUNT = 3'd3,
        EV_ACCEPT  = 3'd4,
        EV_FAILED  = 3'd5,
        EV_NAK     = 3'd6
    } event_kind_t;

    typedef struct packed {
        event_kind_t kind;
        logic [1:0]  alarm;
        logic [5:0]  length;
        logic [63:0] tok_low;
        logic [63:0] tok_high;
        logic [1:0]  failures;
        logic        last;
    } result_t;

endpackage

`default_nettype wire

// File: rtl/card_reader_record_parser_top.sv
// ----------------------------------------------------------------------------
// card_reader_record_parser_top - card reader record parser
// Splits a serial byte stream into tokens and checks them as card records.
// ----------------------------------------------------------------------------
// The block takes one received byte per word and reports date, time, bank
// code and account tokens, an accept or failure word per record and a NAK
// once the line ending after a failure arrives. An accepted byte is held in an
// input register; the parser then decodes it in a single pass and loads the
// results into a two-word result register. While downstream is ready, one
// byte is taken every cycle. The only exception is the byte that closes an
// account or credit number: it yields two words (account, then accept) and
// holds the input while the second word drains. Downstream stalls back up
// through the result register to s_axis_tready. The user must write the
// length limit on the cfg channel only while no bytes are in flight; the
// block does not enforce this. Zero or values above 32 select the 32-byte
// token length.
// ----------------------------------------------------------------------------
`default_nettype none

module card_reader_record_parser_top (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,

    // Configuration: max_token_length
    input  wire logic                              cfg_valid,
    output      logic                              cfg_ready,
    input  wire logic [crp_pkg::CFG_W-1:0]         cfg_data,

    // Input bytes
    input  wire logic                              s_axis_tvalid,
    output      logic                              s_axis_tready,
    input  wire logic [crp_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // [7:0] byte_in
    input  wire logic                              s_axis_tlast,  // end_of_chunk, not parsed

    // Result words
    output      logic                              m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [1:0] alarm_code, [7:2] token_length, [71:8] token_low,
    // [135:72] token_high, [137:136] failure_count, [143:138] zero
    output      logic [crp_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    output      logic [crp_pkg::OUT_USER_W-1:0]    m_axis_tuser,  // [2:0] event_kind
    output      logic                              m_axis_tlast   // last result of a byte
);

    import crp_pkg::*;

    // Parse phases; OK and FAILED only appear between decode and commit
    typedef enum logic [3:0] {
        PH_READER  = 4'd0,
        PH_WEEKDAY = 4'd1,
        PH_DATE    = 4'd2,
        PH_TIME    = 4'd3,
        PH_SEP     = 4'd4,
        PH_BANK    = 4'd5,
        PH_SEPACC  = 4'd6,
        PH_ACCOUNT = 4'd7,
        PH_CREDIT  = 4'd8,
        PH_WAITLF  = 4'd9,
        PH_OK      = 4'd10,
        PH_FAILED  = 4'd11
    } phase_t;

    // Control state
    logic [CFG_W-1:0] cfg_reg;
    logic             in_valid_reg;
    phase_t           phase_reg,    phase_next;
    logic [CNT_W-1:0] count_reg,    count_next;
    logic [1:0]       alarm_reg,    alarm_next;
    logic [1:0]       failures_reg, failures_next;
    logic [1:0]       res_cnt_reg,  res_cnt_next;

    // Payload
    logic [7:0]       byte_reg;
    logic [7:0]       store_reg [TOKEN_STORE_BYTES];
    result_t          head_reg, tail_reg;

    // Decode signals
    logic             fire;
    logic             pop;
    logic [CNT_W-1:0] limit;
    logic             drop;
    logic [CNT_W-1:0] n;
    phase_t           phase_cur;
    phase_t           phase_mid;
    logic             is_delim;
    logic             skip;
    logic             store_wr;
    logic [7:0]       store_char;
    logic             id_shape;
    logic             id_ok;
    logic [1:0]       id_alarm;
    logic [63:0]      tok_low;
    logic [63:0]      tok_high;
    logic             ev1_valid;
    event_kind_t      ev1_kind;
    logic             ev1_token;
    logic             ev2_valid;
    result_t          ev1, ev2;
    result_t          res0, res1;
    logic [1:0]       res_k;

    assign cfg_ready = 1'b1;

    // Decode only when the result register will be empty after this cycle
    assign fire = in_valid_reg &&
                  ((res_cnt_reg == 2'd0) || ((res_cnt_reg == 2'd1) && m_axis_tready));
    assign pop  = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = !in_valid_reg || fire;

    // Effective length limit
    always_comb begin
        if (cfg_reg == '0 || int'(cfg_reg) > MAX_TOKEN) begin
            limit = CNT_W'(MAX_TOKEN);
        end else begin
            limit = CNT_W'(cfg_reg);
        end
    end

    // Over-long token: drop it and restart at the reader id
    assign drop      = count_reg >= limit;
    assign n         = drop ? '0 : count_reg;
    assign phase_cur = drop ? PH_READER : phase_reg;

    assign is_delim   = (byte_reg == CH_SPACE) || (byte_reg == CH_CR) || (byte_reg == CH_LF);
    assign skip       = (n == '0) && (byte_reg == CH_SPACE);
    assign store_char = (byte_reg == CH_NUL) ? CH_SPACE : byte_reg;
    assign store_wr   = fire && !is_delim && (int'(n) < TOKEN_STORE_BYTES);

    // Reader id "L(1)" / "L(2)"
    assign id_shape = (n == CNT_W'(4)) && (store_reg[0] == CH_L) &&
                      (store_reg[1] == CH_OPEN) && (store_reg[3] == CH_CLOSE);
    always_comb begin
        id_ok    = 1'b0;
        id_alarm = ALARM_NONE;
        if (id_shape && store_reg[2] == CH_ONE) begin
            id_ok    = 1'b1;
            id_alarm = ALARM_ONE;
        end else if (id_shape && store_reg[2] == CH_TWO) begin
            id_ok    = 1'b1;
            id_alarm = ALARM_TWO;
        end
    end

    // Token image: bytes past the count read as zero
    always_comb begin
        tok_low  = '0;
        tok_high = '0;
        for (int i = 0; i < REPORT_BYTES; i++) begin
            if (i < TOKEN_STORE_BYTES && CNT_W'(i) < n) begin
                if (i < 8) begin
                    tok_low[i*8 +: 8] = store_reg[i];
                end else begin
                    tok_high[(i-8)*8 +: 8] = store_reg[i];
                end
            end
        end
    end

    // Token sequence check
    always_comb begin
        phase_mid     = phase_cur;
        alarm_next    = alarm_reg;
        failures_next = failures_reg;
        ev1_valid     = 1'b0;
        ev1_kind      = EV_DATE;
        ev1_token     = 1'b0;
        if (is_delim && !skip) begin
            case (phase_cur)
                PH_READER: begin
                    if (n == CNT_W'(4)) alarm_next = id_alarm;
                    if (id_ok) phase_mid = PH_WEEKDAY;
                end
                PH_WEEKDAY: begin
                    phase_mid = (n == CNT_W'(2)) ? PH_DATE : PH_FAILED;
                end
                PH_DATE: begin
                    if (n == CNT_W'(8)) begin
                        ev1_valid = 1'b1;
                        ev1_kind  = EV_DATE;
                        ev1_token = 1'b1;
                        phase_mid = PH_TIME;
                    end else begin
                        phase_mid = PH_FAILED;
                    end
                end
                PH_TIME: begin
                    if (n == CNT_W'(8)) begin
                        ev1_valid = 1'b1;
                        ev1_kind  = EV_TIME;
                        ev1_token = 1'b1;
                        phase_mid = PH_SEP;
                    end else begin
                        phase_mid = PH_FAILED;
                    end
                end
                PH_SEP: begin
                    if (n == CNT_W'(1)) begin
                        phase_mid = PH_CREDIT;
                    end else if (n == CNT_W'(4)) begin
                        phase_mid = PH_BANK;
                    end else begin
                        phase_mid = PH_FAILED;
                    end
                end
                PH_BANK: begin
                    if (n == CNT_W'(8)) begin
                        ev1_valid = 1'b1;
                        ev1_kind  = EV_BANK;
                        ev1_token = 1'b1;
                        phase_mid = PH_SEPACC;
                    end else begin
                        phase_mid = PH_FAILED;
                    end
                end
                PH_SEPACC: begin
                    phase_mid = (n == CNT_W'(4)) ? PH_ACCOUNT : PH_FAILED;
                end
                PH_ACCOUNT: begin
                    if (n >= CNT_W'(10) && n <= CNT_W'(16)) begin
                        ev1_valid = 1'b1;
                        ev1_kind  = EV_ACCOUNT;
                        ev1_token = 1'b1;
                        phase_mid = PH_OK;
                    end else begin
                        phase_mid = PH_FAILED;
                    end
                end
                PH_CREDIT: begin
                    if (n == CNT_W'(16)) begin
                        ev1_valid = 1'b1;
                        ev1_kind  = EV_ACCOUNT;
                        ev1_token = 1'b1;
                        phase_mid = PH_OK;
                    end else begin
                        phase_mid = PH_FAILED;
                    end
                end
                PH_WAITLF: begin
                    if (n == '0 && byte_reg == CH_LF) begin
                        failures_next = failures_reg + 2'd1;
                        ev1_valid     = 1'b1;
                        ev1_kind      = EV_NAK;
                        phase_mid     = PH_READER;
                    end else begin
                        if (n == CNT_W'(4)) alarm_next = id_alarm;
                        if (id_ok) phase_mid = PH_WEEKDAY;
                    end
                end
                default: begin
                    phase_mid = PH_READER;
                end
            endcase
        end

        // Record end: accept or report failure
        ev2_valid  = 1'b0;
        phase_next = phase_mid;
        ev2        = '0;
        if (phase_mid == PH_OK) begin
            failures_next = 2'd0;
            ev2_valid     = 1'b1;
            ev2.kind      = EV_ACCEPT;
            phase_next    = PH_READER;
        end else if (phase_mid == PH_FAILED) begin
            ev2_valid     = 1'b1;
            ev2.kind      = EV_FAILED;
            phase_next    = PH_WAITLF;
        end
        ev2.alarm    = alarm_reg;
        ev2.failures = failures_next;
        ev2.last     = 1'b1;

        // Every delimiter empties the token; other bytes append
        count_next = is_delim ? '0 : n + CNT_W'(1);
    end

    // Assemble result words
    always_comb begin
        ev1          = '0;
        ev1.kind     = ev1_kind;
        ev1.alarm    = alarm_reg;
        ev1.failures = failures_next;
        ev1.last     = !ev2_valid;
        if (ev1_token) begin
            ev1.length   = 6'(n);
            ev1.tok_low  = tok_low;
            ev1.tok_high = tok_high;
            ev1.failures = failures_reg;
        end

        res1 = ev2;
        if (ev1_valid) begin
            res0  = ev1;
            res_k = ev2_valid ? 2'd2 : 2'd1;
        end else begin
            res0  = ev2;
            res_k = ev2_valid ? 2'd1 : 2'd0;
        end
    end

    always_comb begin
        res_cnt_next = res_cnt_reg;
        if (fire) begin
            res_cnt_next = res_k;
        end else if (pop) begin
            res_cnt_next = res_cnt_reg - 2'd1;
        end
    end

    // Control state and output count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg      <= CFG_W'(MAX_TOKEN);
            in_valid_reg <= 1'b0;
            phase_reg    <= PH_READER;
            count_reg    <= '0;
            alarm_reg    <= ALARM_NONE;
            failures_reg <= 2'd0;
            res_cnt_reg  <= 2'd0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                cfg_reg <= cfg_data;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                in_valid_reg <= 1'b1;
            end else if (fire) begin
                in_valid_reg <= 1'b0;
            end
            if (fire) begin
                phase_reg    <= phase_next;
                count_reg    <= count_next;
                alarm_reg    <= alarm_next;
                failures_reg <= failures_next;
            end
            res_cnt_reg <= res_cnt_next;
        end
    end

    // Payload: input byte, token store, result words
    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            byte_reg <= s_axis_tdata;
        end
        if (store_wr) begin
            store_reg[n[STORE_IDX_W-1:0]] <= store_char;
        end
        if (fire) begin
            head_reg <= res0;
            tail_reg <= res1;
        end else if (pop && res_cnt_reg == 2'd2) begin
            head_reg <= tail_reg;
        end
    end

    assign m_axis_tvalid = (res_cnt_reg != 2'd0);
    assign m_axis_tdata  = {6'b0, head_reg.failures, head_reg.tok_high, head_reg.tok_low,
                            head_reg.length, head_reg.alarm};
    assign m_axis_tuser  = head_reg.kind;
    assign m_axis_tlast  = head_reg.last;

endmodule

`default_nettype wire

// File: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - card reader record parser
// Streams short directed sequences and then random card records, noise and
// over-long tokens into the parser under several length limits. A parser
// model runs alongside and predicts every result word, and the monitor checks
// each word field by field against the oldest prediction. Both sides idle at
// random, and long downstream stalls back the block up into its input.
// ----------------------------------------------------------------------------

module testbench;
    import crp_pkg::*;

    localparam int HALF_PERIOD    = 5;
    localparam int PHASES         = 7;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int STALL_CYCLES   = 400;
    localparam int DRAIN_CYCLES   = 16;
    localparam int CFG_GAP        = 8;

    typedef enum logic [3:0] {
        AWAIT_ID, AWAIT_WEEKDAY, AWAIT_DATE, AWAIT_TIME, AWAIT_SEP, AWAIT_BANK,
        AWAIT_ACC_SEP, AWAIT_ACCOUNT, AWAIT_CREDIT, AWAIT_LF, REC_ACCEPTED,
        REC_FAILED
    } rec_phase_t;

    typedef enum logic [1:0] {CARD_UNKNOWN, CARD_CREDIT, CARD_EC} card_kind_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_W-1:0]      cfg_data  = '0;

    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;   // [7:0] byte_in
    logic                  s_axis_tlast  = 1'b0; // end_of_chunk

    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [1:0] alarm_code, [7:2] token_length, [71:8] token_low,
    // [135:72] token_high, [137:136] failure_count, [143:138] zero
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [OUT_USER_W-1:0] m_axis_tuser;         // [2:0] event_kind
    logic                  m_axis_tlast;

    card_reader_record_parser_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // Parser model state
    logic [5:0]  limit_reg  = 6'd32;
    rec_phase_t  rec_phase  = AWAIT_ID;
    card_kind_t  card_kind  = CARD_UNKNOWN;
    logic [7:0]  tok_store [TOKEN_STORE_BYTES];
    int          tok_count  = 0;
    logic [1:0]  alarm      = ALARM_NONE;
    logic [1:0]  failures   = 2'd0;

    result_t     byte_events [$];
    result_t     expected_events [$];
    result_t     want;

    // Pending input words: {end_of_chunk, byte}
    logic [8:0]  byte_q [$];
    logic [8:0]  next_word;
    int          queued_total = 0;
    int          bytes_taken  = 0;

    int          send_idle_pct = 16;
    int          recv_idle_pct = 59;
    int          stall_left    = 0;
    int          stalls_done   = 0;
    int          quiet_cycles  = 0;

    int          results_seen = 0;
    int          accepted     = 0;
    int          failed       = 0;
    int          naks         = 0;
    int          mismatches   = 0;

    int          phase_limit [PHASES] = '{32, 17, 1, 10, 0, 63, 16};
    int          phase_bytes [PHASES] = '{250, 150, 60, 80, 180, 150, 130};

    // ------------------------------------------------------------------------
    // Parser model
    // ------------------------------------------------------------------------
    function automatic void add_event(input event_kind_t kind, input bit with_token);
        result_t ev;
        int      n;
        ev          = '0;
        ev.kind     = kind;
        ev.alarm    = alarm;
        ev.failures = failures;
        if (with_token) begin
            ev.length = 6'(tok_count);
            n = (tok_count < REPORT_BYTES) ? tok_count : REPORT_BYTES;
            for (int i = 0; i < n; i++) begin
                if (i < 8)
                    ev.tok_low[8*i +: 8] = tok_store[i];
                else
                    ev.tok_high[8*(i-8) +: 8] = tok_store[i];
            end
        end
        byte_events.push_back(ev);
    endfunction

    // Only a four-byte token counts as a reader id; it also refreshes the alarm.
    function automatic bit id_matches();
        if (tok_count != 4)
            return 1'b0;
        if (tok_store[0] == CH_L && tok_store[1] == CH_OPEN && tok_store[3] == CH_CLOSE) begin
            if (tok_store[2] == CH_ONE) begin
                alarm = ALARM_ONE;
                return 1'b1;
            end
            if (tok_store[2] == CH_TWO) begin
                alarm = ALARM_TWO;
                return 1'b1;
            end
        end
        alarm = ALARM_NONE;
        return 1'b0;
    endfunction

    function automatic void advance(input rec_phase_t next);
        rec_phase = next;
        tok_count = 0;
    endfunction

    function automatic void parse_byte(input logic [7:0] b);
        int      lim;
        int      n;
        result_t ev;
        lim = (limit_reg == 0 || limit_reg > MAX_TOKEN) ? MAX_TOKEN : int'(limit_reg);
        byte_events.delete();
        // Drop a token that has hit the limit and restart at the reader id
        if (tok_count >= lim) begin
            tok_count = 0;
            rec_phase = AWAIT_ID;
        end
        n = tok_count;
        if (b == CH_SPACE || b == CH_CR || b == CH_LF) begin
            if (!(n == 0 && b == CH_SPACE)) begin
                case (rec_phase)
                    AWAIT_ID: begin
                        if (id_matches())
                            rec_phase = AWAIT_WEEKDAY;
                        tok_count = 0;
                    end
                    AWAIT_WEEKDAY: begin
                        if (n == 2) advance(AWAIT_DATE); else rec_phase = REC_FAILED;
                    end
                    AWAIT_DATE: begin
                        if (n == 8) begin
                            add_event(EV_DATE, 1'b1);
                            advance(AWAIT_TIME);
                        end else rec_phase = REC_FAILED;
                    end
                    AWAIT_TIME: begin
                        if (n == 8) begin
                            add_event(EV_TIME, 1'b1);
                            advance(AWAIT_SEP);
                        end else rec_phase = REC_FAILED;
                    end
                    AWAIT_SEP: begin
                        if (n == 1) begin
                            card_kind = CARD_CREDIT;
                            advance(AWAIT_CREDIT);
                        end else if (n == 4) begin
                            card_kind = CARD_EC;
                            advance(AWAIT_BANK);
                        end else rec_phase = REC_FAILED;
                    end
                    AWAIT_BANK: begin
                        if (n == 8) begin
                            add_event(EV_BANK, 1'b1);
                            advance(AWAIT_ACC_SEP);
                        end else rec_phase = REC_FAILED;
                    end
                    AWAIT_ACC_SEP: begin
                        if (n == 4) advance(AWAIT_ACCOUNT); else rec_phase = REC_FAILED;
                    end
                    AWAIT_ACCOUNT: begin
                        if (n >= 10 && n <= 16) begin
                            add_event(EV_ACCOUNT, 1'b1);
                            advance(REC_ACCEPTED);
                        end else rec_phase = REC_FAILED;
                    end
                    AWAIT_CREDIT: begin
                        if (n == 16) begin
                            add_event(EV_ACCOUNT, 1'b1);
                            advance(REC_ACCEPTED);
                        end else rec_phase = REC_FAILED;
                    end
                    AWAIT_LF: begin
                        if (n == 0 && b == CH_LF) begin
                            failures  = failures + 2'd1;
                            rec_phase = AWAIT_ID;
                            add_event(EV_NAK, 1'b0);
                        end else if (id_matches()) begin
                            rec_phase = AWAIT_WEEKDAY;
                        end
                        tok_count = 0;
                    end
                    default: advance(AWAIT_ID);
                endcase
            end
        end else begin
            // NUL goes into the store as a space; bytes past the store only count
            if (tok_count < TOKEN_STORE_BYTES)
                tok_store[tok_count] = (b == CH_NUL) ? CH_SPACE : b;
            tok_count++;
        end

        if (rec_phase == REC_ACCEPTED) begin
            failures = 2'd0;
            add_event(EV_ACCEPT, 1'b0);
            advance(AWAIT_ID);
        end else if (rec_phase == REC_FAILED) begin
            add_event(EV_FAILED, 1'b0);
            advance(AWAIT_LF);
        end

        if (byte_events.size() != 0) begin
            ev = byte_events.pop_back();
            ev.last = 1'b1;
            byte_events.push_back(ev);
        end
        foreach (byte_events[i])
            expected_events.push_back(byte_events[i]);
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic void push_byte(input logic [7:0] b);
        byte_q.push_back({1'($urandom_range(1)), b});
        queued_total++;
    endfunction

    function automatic logic [7:0] body_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(255));
        while (c == CH_SPACE || c == CH_CR || c == CH_LF);
        return c;
    endfunction

    function automatic void push_token(input int len);
        repeat (len) push_byte(body_char());
    endfunction

    function automatic void push_reader_id(input logic [7:0] digit);
        push_byte(CH_L);
        push_byte(CH_OPEN);
        push_byte(digit);
        push_byte(CH_CLOSE);
    endfunction

    // End a token, now and then followed by spaces that the parser skips
    function automatic void push_delim();
        int r;
        r = $urandom_range(9);
        push_byte(r < 5 ? CH_SPACE : (r < 8 ? CH_CR : CH_LF));
        if ($urandom_range(99) < 20)
            repeat ($urandom_range(2, 1)) push_byte(CH_SPACE);
    endfunction

    // One card record, mostly well formed; a quarter get one field resized.
    function automatic void add_record();
        int lens [$];
        int r;
        int k;
        r = $urandom_range(99);
        if (r < 45)
            push_reader_id(CH_ONE);
        else if (r < 90)
            push_reader_id(CH_TWO);
        else
            push_reader_id(body_char());
        push_delim();
        lens = '{2, 8, 8};
        if ($urandom_range(1) == 1) begin
            lens.push_back(1);
            lens.push_back(16);
        end else begin
            lens.push_back(4);
            lens.push_back(8);
            lens.push_back(4);
            lens.push_back($urandom_range(16, 10));
        end
        if ($urandom_range(99) < 25) begin
            k = $urandom_range(lens.size() - 1);
            lens[k] = $urandom_range(20);
        end
        foreach (lens[i]) begin
            push_token(lens[i]);
            push_delim();
        end
        if ($urandom_range(99) < 30)
            push_byte(CH_LF);
    endfunction

    function automatic void add_noise();
        if ($urandom_range(99) < 30) begin
            push_token($urandom_range(40, 17));
            push_delim();
        end else begin
            repeat ($urandom_range(6, 1)) push_byte(8'($urandom_range(255)));
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] exp_val);
        if (mismatches < 40)
            $display("MISMATCH word %0d: %s got %h, predicted %h", results_seen, what,
                     got, exp_val);
        mismatches++;
    endtask

    // Hold until every queued byte is taken and every predicted word is in
    task automatic settle(input int extra);
        while (bytes_taken != queued_total || expected_events.size() != 0)
            @(posedge aclk);
        repeat (extra) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Driver: offer the next byte once the current word is taken
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                parse_byte(s_axis_tdata);
                bytes_taken <= bytes_taken + 1;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_word = byte_q.pop_front();
                    s_axis_tdata  <= next_word[7:0];
                    s_axis_tlast  <= next_word[8];
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Long downstream hold-offs while the sender keeps offering bytes
    always @(posedge aclk) begin
        if (!aresetn) begin
            stall_left <= 0;
        end else if ((stalls_done == 0 && bytes_taken >= 320) ||
                     (stalls_done == 1 && bytes_taken >= 870)) begin
            stall_left  <= STALL_CYCLES;
            stalls_done <= stalls_done + 1;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check every result word against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                case (m_axis_tuser)
                    EV_ACCEPT: accepted++;
                    EV_FAILED: failed++;
                    EV_NAK:    naks++;
                    default: ;
                endcase
                if (expected_events.size() == 0) begin
                    report_mismatch("word with nothing pending", 64'(m_axis_tuser), '0);
                end else begin
                    want = expected_events.pop_front();
                    if (m_axis_tuser !== want.kind)
                        report_mismatch("event_kind", 64'(m_axis_tuser), 64'(want.kind));
                    if (m_axis_tdata[1:0] !== want.alarm)
                        report_mismatch("alarm_code", 64'(m_axis_tdata[1:0]), 64'(want.alarm));
                    if (m_axis_tdata[7:2] !== want.length)
                        report_mismatch("token_length", 64'(m_axis_tdata[7:2]),
                                        64'(want.length));
                    if (m_axis_tdata[71:8] !== want.tok_low)
                        report_mismatch("token_low", m_axis_tdata[71:8], want.tok_low);
                    if (m_axis_tdata[135:72] !== want.tok_high)
                        report_mismatch("token_high", m_axis_tdata[135:72], want.tok_high);
                    if (m_axis_tdata[137:136] !== want.failures)
                        report_mismatch("failure_count", 64'(m_axis_tdata[137:136]),
                                        64'(want.failures));
                    if (m_axis_tdata[143:138] !== 6'd0)
                        report_mismatch("padding", 64'(m_axis_tdata[143:138]), '0);
                    if (m_axis_tlast !== want.last)
                        report_mismatch("last", 64'(m_axis_tlast), 64'(want.last));
                end
            end
            m_axis_tready <= (stall_left == 0) && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: give up after a long stretch with no word moving anywhere
    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        int budget_end;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: skipped leading space, NUL in a token, failure then NAK,
        // reader id while waiting for the line end, byte extremes
        push_byte(CH_SPACE);
        push_reader_id(CH_TWO);
        push_byte(CH_CR);
        push_byte(CH_NUL);
        push_byte(8'hFF);
        push_byte(CH_LF);
        push_byte(CH_CR);
        push_byte(CH_LF);
        push_reader_id(CH_ONE);
        push_byte(CH_SPACE);
        push_byte(CH_SPACE);
        push_token(2);
        push_byte(CH_LF);
        push_token(1);
        push_byte(CH_CR);
        push_reader_id(CH_TWO);
        push_byte(CH_CR);
        push_token(2);
        push_byte(CH_SPACE);
        push_byte(CH_LF);
        push_byte(CH_LF);

        for (int p = 0; p < PHASES; p++) begin
            // Let the block go idle, then write the new length limit
            settle(CFG_GAP);
            @(posedge aclk);
            cfg_data  <= CFG_W'(phase_limit[p]);
            cfg_valid <= 1'b1;
            do
                @(posedge aclk);
            while (!cfg_ready);
            cfg_valid <= 1'b0;
            limit_reg = CFG_W'(phase_limit[p]);

            if (p == 3) begin
                send_idle_pct = 59;
                recv_idle_pct = 16;
            end else if (p == 5) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            budget_end = queued_total + phase_bytes[p];
            while (queued_total < budget_end) begin
                if ($urandom_range(99) < 15)
                    add_noise();
                else
                    add_record();
            end
        end

        settle(DRAIN_CYCLES);
        $display("Covered %0d bytes under %0d length limits and %0d result words.",
                 bytes_taken, PHASES + 1, results_seen);
        $display("Records accepted %0d, failure reports %0d, NAKs %0d, mismatches %0d.",
                 accepted, failed, naks, mismatches);
        if (mismatches == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
